>>> hdl/height_field_wave_step_assert.svh
// Assertion macros shared by the checker files of the height field wave step.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef HEIGHT_FIELD_WAVE_STEP_ASSERT_SVH
`define HEIGHT_FIELD_WAVE_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HFW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hfw_pkg.sv
// Package of the height field wave step: field widths, register codes and reset
// values, and the types passed between the sequencer and the arithmetic unit.
// Depends on nothing.
package hfw_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned ROW_LEN_W   = 6;
  localparam int unsigned ROW_CNT_W   = 13;
  localparam int unsigned ROW_IDX_W   = 12;
  localparam int unsigned DAMP_W      = 9;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned MAX_ROW_DEF = 32;

  localparam int unsigned SUM_W  = DATA_W + 2;
  localparam int unsigned X_W    = DATA_W + 2;
  localparam int unsigned PROD_W = X_W + DAMP_W + 1;

  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = ROW_LEN_W'(32);
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_RST = ROW_CNT_W'(32);
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_MIN = ROW_CNT_W'(2);
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = ROW_CNT_W'(4096);
  localparam logic [DAMP_W-1:0]    DAMP_RST    = DAMP_W'(205);
  localparam logic [DAMP_W-1:0]    DAMP_ONE    = DAMP_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 2'd0,
    CFG_ROW_COUNT  = 2'd1,
    CFG_DAMPING    = 2'd2
  } hfw_cfg_idx_e;

  // Stencil operands for one grid point.
  typedef struct packed {
    logic signed [DATA_W-1:0] ctr;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] dn;
    logic signed [DATA_W-1:0] lf;
    logic signed [DATA_W-1:0] rt;
    logic signed [DATA_W-1:0] vel;
  } hfw_operands_t;

  // Stage enables of the arithmetic unit.
  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } hfw_calc_ctrl_t;

endpackage

>>> hdl/hfw_if.sv
// Handshake channels of the height field wave step: input points, results and
// configuration writes. Depends on hfw_pkg.
interface hfw_in_if import hfw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] height;
  logic signed [DATA_W-1:0] velocity;

  modport source (output valid, output height, output velocity, input ready);
  modport sink   (input valid, input height, input velocity, output ready);
endinterface

interface hfw_out_if import hfw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_height;
  logic signed [DATA_W-1:0] new_velocity;
  logic                     run_last;
  logic                     frame_end;

  modport source (output valid, output new_height, output new_velocity,
                  output run_last, output frame_end, input ready);
  modport sink   (input valid, input new_height, input new_velocity,
                  input run_last, input frame_end, output ready);
endinterface

interface hfw_cfg_if import hfw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/hfw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module hfw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 66,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/hfw_calc.sv
// Arithmetic unit of the wave step: neighbor average, damped velocity multiply
// and the two saturations. Depends on hfw_pkg.
module hfw_calc import hfw_pkg::*; (
  input  logic                     clk_i,
  input  hfw_calc_ctrl_t           ctrl_i,
  input  hfw_operands_t            op_i,
  input  logic [DAMP_W-1:0]        damp_i,
  output logic signed [DATA_W-1:0] new_height_o,
  output logic signed [DATA_W-1:0] new_velocity_o
);

  localparam int unsigned NV_W = PROD_W - 8;

  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W:0]   goal;
  logic signed [X_W-1:0]    x_d, x_q;
  logic signed [DATA_W-1:0] c1_q, c2_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [NV_W-1:0]   nv_wide;
  logic signed [DATA_W-1:0] nv;
  logic signed [DATA_W:0]   nh_wide;

  function automatic logic signed [DATA_W-1:0] sat_nv(input logic signed [NV_W-1:0] x);
    if (x > NV_W'(32767)) begin
      return DATA_W'(32767);
    end else if (x < -NV_W'(32768)) begin
      return DATA_W'(-32768);
    end
    return DATA_W'(x);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_nh(input logic signed [DATA_W:0] x);
    if (x > (DATA_W+1)'(32767)) begin
      return DATA_W'(32767);
    end else if (x < -(DATA_W+1)'(32768)) begin
      return DATA_W'(-32768);
    end
    return DATA_W'(x);
  endfunction

  // The arithmetic shift floors, matching a division rounded toward minus infinity.
  assign sum  = SUM_W'(op_i.up) + SUM_W'(op_i.dn) + SUM_W'(op_i.lf) + SUM_W'(op_i.rt);
  assign goal = (DATA_W+1)'(sum >>> 2) - (DATA_W+1)'(op_i.ctr);
  assign x_d  = X_W'(goal) + X_W'(op_i.vel);

  assign prod_d = PROD_W'(x_q) * PROD_W'($signed({1'b0, damp_i}));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      x_q  <= x_d;
      c1_q <= op_i.ctr;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
      c2_q   <= c1_q;
    end
  end

  assign nv_wide = NV_W'(prod_q >>> 8);
  assign nv      = sat_nv(nv_wide);
  assign nh_wide = (DATA_W+1)'(c2_q) + (DATA_W+1)'(nv);

  assign new_velocity_o = nv;
  assign new_height_o   = sat_nh(nh_wide);

endmodule

>>> hdl/height_field_wave_step.sv
// Top level of the height field wave step: configuration registers, raster
// sequencer, height and velocity delay memories and the output register.
// Depends on hfw_pkg, hfw_if, hfw_ram and hfw_calc.
//
//   channel  | dir | payload                                          | accepted when
//   ---------+-----+--------------------------------------------------+--------------------
//   cfg_i    | in  | index, data                                      | cfg_i.valid & ready
//   in_i     | in  | height, velocity                                 | in_i.valid & ready
//   out_o    | out | new_height, new_velocity, run_last, frame_end    | out_o.valid & ready
//
// A point of the first row yields no result. Any other point passes through the write
// of the delay memories, four reads of the single height memory port plus one capture,
// then the sum, multiply and output stages. The last point of the frame then repeats
// the reads and stages for each point of the last row, row_length in all.
// Reset needs no clearing pass; memory data is only used where written earlier.
// A full output register holds the sequencer in its output stage until taken.
module height_field_wave_step import hfw_pkg::*; #(
  parameter int unsigned MaxRow = MAX_ROW_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hfw_cfg_if.sink       cfg_i,
  hfw_in_if.sink        in_i,
  hfw_out_if.source     out_o
);

  // The height memory holds the last two rows plus two points, the velocity memory
  // one row plus one point. Both are circular, addressed backward from the newest entry.
  localparam int unsigned HDepth = 2 * MaxRow + 2;
  localparam int unsigned VDepth = MaxRow + 1;
  localparam int unsigned HAW    = $clog2(HDepth);
  localparam int unsigned VAW    = $clog2(VDepth);
  localparam int unsigned LW     = $clog2(MaxRow + 1);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_RD_CTR   = 9'b000000010,
    ST_RD_UP    = 9'b000000100,
    ST_RD_LEFT  = 9'b000001000,
    ST_RD_RIGHT = 9'b000010000,
    ST_CAPTURE  = 9'b000100000,
    ST_SUM      = 9'b001000000,
    ST_MUL      = 9'b010000000,
    ST_OUT      = 9'b100000000
  } hfw_state_e;

  hfw_state_e state_d, state_q;

  logic [ROW_LEN_W-1:0] row_length_q;
  logic [ROW_CNT_W-1:0] row_count_q;
  logic [DAMP_W-1:0]    damping_q;

  logic [LW-1:0]        eff_len;
  logic [ROW_CNT_W-1:0] eff_cnt;
  logic [DAMP_W-1:0]    eff_damp;

  logic [LW-1:0]        col_d, col_q;
  logic [ROW_IDX_W-1:0] row_d, row_q;
  logic [HAW-1:0]       wp_d, wp_q;
  logic [VAW-1:0]       vp_d, vp_q;

  // Base offset of the current point's center in the height delay line.
  logic [LW-1:0] base_d, base_q;
  logic          use_up_d, use_up_q;
  logic          use_lf_d, use_lf_q;
  logic          use_rt_d, use_rt_q;
  logic          flush_d, flush_q;
  logic          in_flush_d, in_flush_q;

  logic signed [DATA_W-1:0] h_in_q;
  hfw_operands_t            op_q;

  logic                 in_acc;
  logic                 last_col, last_row;
  logic                 out_load;
  logic                 out_valid_q;
  logic [HAW-1:0]       hoff;
  logic [HAW-1:0]       hraddr;
  logic [VAW-1:0]       vraddr;
  logic [DATA_W-1:0]    hrdata, vrdata;
  hfw_calc_ctrl_t       calc_ctrl;
  logic signed [DATA_W-1:0] calc_nh, calc_nv;

  logic signed [DATA_W-1:0] nh_q, nv_q;
  logic                     run_last_q, frame_end_q;

  function automatic logic [HAW-1:0] hwrap(input logic [HAW-1:0] ptr,
                                           input logic [HAW-1:0] off);
    logic [HAW:0] s;
    s = {1'b0, ptr} + (HAW+1)'(HDepth) - {1'b0, off};
    if (s >= (HAW+1)'(HDepth)) begin
      s = s - (HAW+1)'(HDepth);
    end
    return s[HAW-1:0];
  endfunction

  function automatic logic [VAW-1:0] vwrap(input logic [VAW-1:0] ptr,
                                           input logic [VAW-1:0] off);
    logic [VAW:0] s;
    s = {1'b0, ptr} + (VAW+1)'(VDepth) - {1'b0, off};
    if (s >= (VAW+1)'(VDepth)) begin
      s = s - (VAW+1)'(VDepth);
    end
    return s[VAW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration. The user must write only while the block is idle; the block does not
  // enforce it. Unknown indexes are dropped. Effective values clamp registers to legal range.
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= ROW_LEN_RST;
      row_count_q  <= ROW_CNT_RST;
      damping_q    <= DAMP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ROW_LENGTH: row_length_q <= cfg_i.data[ROW_LEN_W-1:0];
        CFG_ROW_COUNT:  row_count_q  <= cfg_i.data[ROW_CNT_W-1:0];
        CFG_DAMPING:    damping_q    <= cfg_i.data[DAMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (row_length_q < ROW_LEN_W'(2)) begin
      eff_len = LW'(2);
    end else if (int'(row_length_q) > int'(MaxRow)) begin
      eff_len = LW'(MaxRow);
    end else begin
      eff_len = LW'(row_length_q);
    end

    if (row_count_q < ROW_CNT_MIN) begin
      eff_cnt = ROW_CNT_MIN;
    end else if (row_count_q > ROW_CNT_MAX) begin
      eff_cnt = ROW_CNT_MAX;
    end else begin
      eff_cnt = row_count_q;
    end

    eff_damp = (damping_q > DAMP_ONE) ? DAMP_ONE : damping_q;
  end

  // ---------------------------------------------------------------------------
  // Raster position and delay line pointers.
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign last_col = ({1'b0, col_q} + (LW+1)'(1)) >= {1'b0, eff_len};
  assign last_row = ({1'b0, row_q} + ROW_CNT_W'(1)) >= eff_cnt;

  assign wp_d = (wp_q == HAW'(HDepth - 1)) ? '0 : wp_q + HAW'(1);
  assign vp_d = (vp_q == VAW'(VDepth - 1)) ? '0 : vp_q + VAW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col && last_row) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_q + ROW_IDX_W'(1);
      end else begin
        col_d = col_q + LW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. Each point reads its center, upper, left and right heights one per
  // cycle through the height memory's read port; the velocity is read with the center.
  // Neighbors outside the grid fall back to the center height at capture.
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    use_up_d   = use_up_q;
    use_lf_d   = use_lf_q;
    use_rt_d   = use_rt_q;
    flush_d    = flush_q;
    in_flush_d = in_flush_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // The point one row above the newest input gets its result now.
          base_d     = eff_len;
          use_up_d   = (row_q >= ROW_IDX_W'(2));
          use_lf_d   = (col_q != '0);
          use_rt_d   = !last_col;
          flush_d    = last_col && last_row;
          in_flush_d = 1'b0;
          state_d    = (row_q != '0) ? ST_RD_CTR : ST_IDLE;
        end
      end
      ST_RD_CTR:   state_d = ST_RD_UP;
      ST_RD_UP:    state_d = ST_RD_LEFT;
      ST_RD_LEFT:  state_d = ST_RD_RIGHT;
      ST_RD_RIGHT: state_d = ST_CAPTURE;
      ST_CAPTURE:  state_d = ST_SUM;
      ST_SUM:      state_d = ST_MUL;
      ST_MUL:      state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          if (flush_q && !in_flush_q) begin
            // End of frame: walk the last row left to right, which it has no row below.
            in_flush_d = 1'b1;
            base_d     = eff_len - LW'(1);
            use_up_d   = 1'b1;
            use_lf_d   = 1'b0;
            use_rt_d   = 1'b1;
            state_d    = ST_RD_CTR;
          end else if (in_flush_q && (base_q != '0)) begin
            base_d   = base_q - LW'(1);
            use_lf_d = 1'b1;
            use_rt_d = (base_q != LW'(1));
            state_d  = ST_RD_CTR;
          end else begin
            flush_d    = 1'b0;
            in_flush_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      wp_q       <= '0;
      vp_q       <= '0;
      base_q     <= '0;
      use_up_q   <= 1'b0;
      use_lf_q   <= 1'b0;
      use_rt_q   <= 1'b0;
      flush_q    <= 1'b0;
      in_flush_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      base_q     <= base_d;
      use_up_q   <= use_up_d;
      use_lf_q   <= use_lf_d;
      use_rt_q   <= use_rt_d;
      flush_q    <= flush_d;
      in_flush_q <= in_flush_d;
      if (in_acc) begin
        wp_q <= wp_d;
        vp_q <= vp_d;
      end
    end
  end

  // Read offsets back from the newest height: center, above, left, right.
  always_comb begin
    case (state_q)
      ST_RD_UP:    hoff = HAW'(base_q) + HAW'(eff_len);
      ST_RD_LEFT:  hoff = HAW'(base_q) + HAW'(1);
      ST_RD_RIGHT: hoff = (base_q == '0) ? HAW'(base_q) : HAW'(base_q) - HAW'(1);
      default:     hoff = HAW'(base_q);
    endcase
  end

  assign hraddr = hwrap(wp_q, hoff);
  assign vraddr = vwrap(vp_q, VAW'(base_q));

  hfw_ram #(
    .Width(DATA_W),
    .Depth(HDepth)
  ) u_height_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(wp_d),
    .wdata_i(in_i.height),
    .raddr_i(hraddr),
    .rdata_o(hrdata)
  );

  hfw_ram #(
    .Width(DATA_W),
    .Depth(VDepth)
  ) u_velocity_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(vp_d),
    .wdata_i(in_i.velocity),
    .raddr_i(vraddr),
    .rdata_o(vrdata)
  );

  // Operand capture: read data shows in the cycle after its address.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      h_in_q <= in_i.height;
    end
    case (state_q)
      ST_RD_UP: begin
        op_q.ctr <= $signed(hrdata);
        op_q.vel <= $signed(vrdata);
      end
      ST_RD_LEFT:  op_q.up <= use_up_q ? $signed(hrdata) : op_q.ctr;
      ST_RD_RIGHT: op_q.lf <= use_lf_q ? $signed(hrdata) : op_q.ctr;
      ST_CAPTURE: begin
        op_q.rt <= use_rt_q ? $signed(hrdata) : op_q.ctr;
        op_q.dn <= in_flush_q ? op_q.ctr : h_in_q;
      end
      default: begin
      end
    endcase
  end

  assign calc_ctrl.sum_en = (state_q == ST_SUM);
  assign calc_ctrl.mul_en = (state_q == ST_MUL);

  hfw_calc u_calc (
    .clk_i         (clk_i),
    .ctrl_i        (calc_ctrl),
    .op_i          (op_q),
    .damp_i        (eff_damp),
    .new_height_o  (calc_nh),
    .new_velocity_o(calc_nv)
  );

  // ---------------------------------------------------------------------------
  // Output register. It decouples the result consumer from the input side.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      nh_q        <= calc_nh;
      nv_q        <= calc_nv;
      run_last_q  <= in_flush_q ? (base_q == '0) : !flush_q;
      frame_end_q <= in_flush_q && (base_q == '0);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.new_height   = nh_q;
  assign out_o.new_velocity = nv_q;
  assign out_o.run_last     = run_last_q;
  assign out_o.frame_end    = frame_end_q;

endmodule

>>> hdl/hfw_checker.sv
// Port-level checker of the height field wave step, bound to the top level.
// Depends on hfw_pkg and height_field_wave_step_assert.svh.
`include "height_field_wave_step_assert.svh"

module hfw_checker import hfw_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] out_new_height_i,
  input logic [DATA_W-1:0] out_new_velocity_i,
  input logic              out_run_last_i,
  input logic              out_frame_end_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A result needs a series of memory reads; it never follows an accept directly.
  `HFW_ASSERT_IMPL(a_no_instant_result, clk_i, rst_ni, $rose(out_valid_i), !$past(in_acc), "result right after accept")

  // The frame's final point is always the last result of its request.
  `HFW_ASSERT_IMPL(a_frame_end_last, clk_i, rst_ni, out_valid_i && out_frame_end_i, out_run_last_i, "frame end without run last")

  `HFW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_new_height_i) && $stable(out_new_velocity_i) && $stable(out_run_last_i) && $stable(out_frame_end_i), "stalled result changed")

endmodule

bind height_field_wave_step hfw_checker u_hfw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_new_height_i  (out_o.new_height),
  .out_new_velocity_i(out_o.new_velocity),
  .out_run_last_i    (out_o.run_last),
  .out_frame_end_i   (out_o.frame_end)
);

>>> test/hfw_wave_checker.sv
`timescale 1ns / 100ps
// Checker of the height field wave step: watches the configuration, point and
// result channels, models the stencil update and compares every result taken.
// Depends on hfw_pkg and hfw_if.
module hfw_wave_checker import hfw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hfw_cfg_if          cfg_i,
  hfw_in_if           pts_i,
  hfw_out_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned HIST_H = 2 * MAX_ROW_DEF + 2;
  localparam int unsigned HIST_V = MAX_ROW_DEF + 1;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_height;
    logic signed [DATA_W-1:0] new_velocity;
    logic                     run_last;
    logic                     frame_end;
  } wave_result_t;

  logic [ROW_LEN_W-1:0]     row_length_q;
  logic [ROW_CNT_W-1:0]     row_count_q;
  logic [DAMP_W-1:0]        damping_q;
  logic signed [DATA_W-1:0] height_hist [HIST_H];
  logic signed [DATA_W-1:0] velocity_hist [HIST_V];
  int unsigned              row_pos, col_pos;
  int unsigned              mismatches, results_seen;
  wave_result_t             pending_points [$];

  function automatic int sat16(int x);
    if (x > 32767) begin
      return 32767;
    end
    if (x < -32768) begin
      return -32768;
    end
    return x;
  endfunction

  // One relaxation step of a single grid point; both shifts floor toward minus infinity.
  function automatic wave_result_t relax_point(int ctr, int up, int dn, int lf, int rt,
                                               int vel, int damp, logic fend);
    wave_result_t r;
    int goal, nv, nh;
    goal = ((up + dn + lf + rt) >>> 2) - ctr;
    nv = sat16(((vel + goal) * damp) >>> 8);
    nh = sat16(ctr + nv);
    r.new_height   = nh[DATA_W-1:0];
    r.new_velocity = nv[DATA_W-1:0];
    r.run_last     = 1'b0;
    r.frame_end    = fend;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : grid_model
    int unsigned  len, rows, k, c;
    int           dmp, ctr, up, lf, rt;
    logic         last_col, last_row;
    wave_result_t batch [$];
    wave_result_t want, seen;
    if (!rst_ni) begin
      row_length_q = ROW_LEN_RST;
      row_count_q  = ROW_CNT_RST;
      damping_q    = DAMP_RST;
      for (k = 0; k < HIST_H; k++) begin
        height_hist[k] = '0;
      end
      for (k = 0; k < HIST_V; k++) begin
        velocity_hist[k] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      mismatches = 0;
      results_seen = 0;
      pending_points.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_ROW_LENGTH: row_length_q = cfg_i.data[ROW_LEN_W-1:0];
          CFG_ROW_COUNT:  row_count_q  = cfg_i.data[ROW_CNT_W-1:0];
          CFG_DAMPING:    damping_q    = cfg_i.data[DAMP_W-1:0];
          default: ;
        endcase
      end

      if (res_i.valid && res_i.ready) begin
        seen = '{res_i.new_height, res_i.new_velocity, res_i.run_last, res_i.frame_end};
        if (pending_points.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: result %0d arrived with none outstanding: h=%0d v=%0d last=%b end=%b",
                     $time, results_seen, seen.new_height, seen.new_velocity,
                     seen.run_last, seen.frame_end);
          end
          mismatches++;
        end else begin
          want = pending_points.pop_front();
          if (seen !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: result %0d expected h=%0d v=%0d last=%b end=%b, got h=%0d v=%0d last=%b end=%b",
                       $time, results_seen, want.new_height, want.new_velocity,
                       want.run_last, want.frame_end, seen.new_height, seen.new_velocity,
                       seen.run_last, seen.frame_end);
            end
            mismatches++;
          end
        end
        results_seen++;
      end

      if (pts_i.valid && pts_i.ready) begin
        len = (row_length_q < 2) ? 2 : ((row_length_q > MAX_ROW_DEF) ? MAX_ROW_DEF : row_length_q);
        rows = (row_count_q < ROW_CNT_MIN) ? ROW_CNT_MIN :
               ((row_count_q > ROW_CNT_MAX) ? ROW_CNT_MAX : row_count_q);
        dmp = (damping_q > DAMP_ONE) ? int'(DAMP_ONE) : int'(damping_q);
        last_col = (col_pos + 1 >= len);
        last_row = (row_pos + 1 >= rows);
        batch.delete();

        for (k = HIST_H - 1; k > 0; k--) begin
          height_hist[k] = height_hist[k-1];
        end
        for (k = HIST_V - 1; k > 0; k--) begin
          velocity_hist[k] = velocity_hist[k-1];
        end
        height_hist[0]   = pts_i.height;
        velocity_hist[0] = pts_i.velocity;

        // The newest point is the lower neighbor of the point one row back.
        if (row_pos >= 1) begin
          ctr = height_hist[len];
          up  = (row_pos >= 2) ? height_hist[2*len] : ctr;
          lf  = (col_pos >= 1) ? height_hist[len+1] : ctr;
          rt  = last_col ? ctr : height_hist[len-1];
          batch = {batch, relax_point(ctr, up, height_hist[0], lf, rt,
                                      velocity_hist[len], dmp, 1'b0)};
        end

        // The final point of the frame drains the bottom row, which has no lower neighbor.
        if (last_row && last_col) begin
          for (c = 0; c < len; c++) begin
            ctr = height_hist[len-1-c];
            up  = height_hist[2*len-1-c];
            lf  = (c >= 1) ? height_hist[len-c] : ctr;
            rt  = (c + 1 < len) ? height_hist[len-2-c] : ctr;
            batch = {batch, relax_point(ctr, up, ctr, lf, rt, velocity_hist[len-1-c],
                                        dmp, c + 1 == len)};
          end
          row_pos = 0;
          col_pos = 0;
        end else if (last_col) begin
          col_pos = 0;
          row_pos = (row_pos + 1) % 4096;
        end else begin
          col_pos = (col_pos + 1) % 64;
        end

        if (batch.size() > 0) begin
          batch[batch.size()-1].run_last = 1'b1;
        end
        pending_points = {pending_points, batch};
      end

      fail_count_o <= mismatches;
      pending_o <= pending_points.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Testbench top of the height field wave step: clock, reset, frame stimulus,
// result-side stalls, watchdog and verdict. Depends on hfw_pkg, hfw_if,
// hfw_wave_checker and the height_field_wave_step RTL.
module tb;
  import hfw_pkg::*;

  // A cycle with no request taken on any channel counts toward this limit. The
  // longest honest silence is a receiver stall.
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_POINTS = 140;
  localparam int unsigned FRAME_SLACK   = 16;
  localparam int unsigned SETTLE_CYCLES = 40;

  // Index 3 addresses no register; a write there must leave everything alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] FIELD_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] FIELD_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_BURSTY
  } drain_mode_e;

  typedef enum logic [1:0] {
    SURFACE_NOISE,
    SURFACE_SMOOTH,
    SURFACE_EXTREME
  } surface_e;

  logic clk = 1'b0;
  logic rst_n;

  hfw_cfg_if cfg_ch ();
  hfw_in_if  pts_ch ();
  hfw_out_if res_ch ();

  int unsigned fail_count, pending;
  int unsigned grid_cols, grid_rows;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned drain_timer = 0;
  int unsigned drain_hold = 0;
  int unsigned random_points = 0;
  drain_mode_e drain_mode = DRAIN_FREE;
  logic signed [DATA_W-1:0] surface_base = '0;

  height_field_wave_step uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (pts_ch),
    .out_o  (res_ch)
  );

  hfw_wave_checker wave_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_ch),
    .pts_i        (pts_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The result side switches at random between stall patterns: always
  // ready, ready three times out of four, and long stalls broken by ready stretches.
  always @(posedge clk) begin
    if (drain_timer == 0) begin
      drain_mode  = drain_mode_e'($urandom_range(0, 2));
      drain_timer = $urandom_range(20, 200);
    end else begin
      drain_timer--;
    end
    case (drain_mode)
      DRAIN_FREE:   res_ch.ready <= 1'b1;
      DRAIN_RANDOM: res_ch.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (drain_hold != 0) begin
          drain_hold--;
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) begin
            drain_hold = $urandom_range(1, 30);
          end
        end
      end
    endcase
  end

  // The watchdog ends a run that has stopped making progress on every channel.
  always @(posedge clk) begin
    if ((pts_ch.valid && pts_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("height_field_wave_step: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes all three registers back to back, then index 3 if with_spare is set,
  // holding valid high across the writes, and records the geometry that the block
  // will actually use. Unused upper data bits carry random junk, which the block has to drop.
  task automatic program_grid(input logic [ROW_LEN_W-1:0] len,
                              input logic [ROW_CNT_W-1:0] cnt,
                              input logic [DAMP_W-1:0] damp,
                              input logic with_spare);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int unsigned           n, k;
    idx[0] = CFG_ROW_LENGTH;
    val[0] = CFG_DATA_W'($urandom);
    val[0][ROW_LEN_W-1:0] = len;
    idx[1] = CFG_ROW_COUNT;
    val[1] = cnt;
    idx[2] = CFG_DAMPING;
    val[2] = CFG_DATA_W'($urandom);
    val[2][DAMP_W-1:0] = damp;
    idx[3] = CFG_SPARE;
    val[3] = CFG_DATA_W'($urandom);
    n = with_spare ? 4 : 3;
    for (k = 0; k < n; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    grid_cols = (len < 2) ? 2 : ((len > MAX_ROW_DEF) ? MAX_ROW_DEF : len);
    grid_rows = (cnt < ROW_CNT_MIN) ? ROW_CNT_MIN : ((cnt > ROW_CNT_MAX) ? ROW_CNT_MAX : cnt);
  endtask

  // Presents one grid point and returns at the edge where it is taken. The sender
  // runs in bursts; a new burst may start after a gap with valid low. Valid is not
  // lowered after a request, so back-to-back points keep it high.
  task automatic send_point(input logic signed [DATA_W-1:0] height,
                            input logic signed [DATA_W-1:0] velocity);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        pts_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 8);
    end
    pts_ch.valid    <= 1'b1;
    pts_ch.height   <= height;
    pts_ch.velocity <= velocity;
    @(posedge clk);
    while (!pts_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Drops valid, waits until every predicted result has been taken, and lets the
  // block run on a little so that a stray result would still be seen.
  task automatic settle();
    pts_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Smooth surfaces keep the arithmetic mostly unsaturated; noise and extremes
  // drive it into both rails.
  function automatic logic signed [DATA_W-1:0] surface_sample(input surface_e style,
                                                             input int center,
                                                             input int spread);
    int s;
    case (style)
      SURFACE_NOISE: return DATA_W'($urandom);
      SURFACE_SMOOTH: begin
        s = center + int'($urandom_range(0, 2 * spread)) - spread;
        return s[DATA_W-1:0];
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return FIELD_MAX;
          1:       return FIELD_MIN;
          2:       return '0;
          default: return DATA_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Streams one whole frame in raster order with the current geometry.
  task automatic run_frame(input surface_e style);
    int unsigned n;
    surface_base = DATA_W'($urandom_range(0, 16383) - 8192);
    for (n = 0; n < grid_cols * grid_rows; n++) begin
      send_point(surface_sample(style, surface_base, 256), surface_sample(style, 0, 64));
    end
  endtask

  initial begin
    int unsigned              r, c, frames;
    logic [ROW_LEN_W-1:0]     len;
    logic [ROW_CNT_W-1:0]     cnt;
    logic [DAMP_W-1:0]        damp;
    int                       h, v;

    rst_n           <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_ROW_LENGTH;
    cfg_ch.data     <= '0;
    pts_ch.valid    <= 1'b0;
    pts_ch.height   <= '0;
    pts_ch.velocity <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest grid, damping written above one so it clamps to exactly one, and
    // full-scale heights and velocities in every combination. This drives both
    // saturation rails and a frame whose every point sits on an edge.
    program_grid(2, 2, 9'd511, 1'b1);
    send_point(FIELD_MAX, FIELD_MAX);
    send_point(FIELD_MIN, FIELD_MIN);
    send_point(FIELD_MAX, FIELD_MIN);
    send_point(FIELD_MIN, FIELD_MAX);
    settle();

    // Row length zero and row count one both clamp to two; zero damping must
    // freeze every point in place.
    program_grid(0, 1, 9'd0, 1'b1);
    send_point(16'sh0001, -16'sh0001);
    send_point(16'sh5555, 16'shAAAA);
    send_point(16'shAAAA, 16'sh5555);
    send_point(16'shFFFF, 16'sh0001);
    settle();

    // A three by three grid has one interior point with all four real neighbors,
    // plus corners and edges of both kinds, under undamped motion.
    program_grid(3, 3, 9'd256, 1'b0);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        h = int'(r * 3 + c) * 3000 - 12000;
        v = (int'(c) - int'(r)) * 500;
        send_point(h[DATA_W-1:0], v[DATA_W-1:0]);
      end
    end
    settle();

    // Random phases: each picks a geometry and damping, mostly small grids with
    // the clamped extremes mixed in, and streams one or two whole frames. A frame
    // that would run well past the point budget is skipped.
    while (random_points < RANDOM_POINTS) begin
      case ($urandom_range(0, 5))
        0:       len = $urandom_range(0, 1) ? ROW_LEN_W'($urandom_range(33, 63)) : ROW_LEN_W'(32);
        1:       len = ROW_LEN_W'($urandom_range(0, 2));
        2:       len = ROW_LEN_W'($urandom_range(9, 31));
        default: len = ROW_LEN_W'($urandom_range(2, 8));
      endcase
      cnt = ($urandom_range(0, 3) == 0) ? ROW_CNT_W'($urandom_range(0, 1))
                                         : ROW_CNT_W'($urandom_range(2, 5));
      case ($urandom_range(0, 5))
        0:       damp = '0;
        1:       damp = DAMP_ONE;
        2:       damp = DAMP_W'($urandom_range(257, 511));
        3:       damp = DAMP_W'(255);
        default: damp = DAMP_W'($urandom_range(0, 511));
      endcase
      program_grid(len, cnt, damp, $urandom_range(0, 1));
      frames = $urandom_range(1, 2);
      repeat (frames) begin
        if (random_points + grid_cols * grid_rows <= RANDOM_POINTS + FRAME_SLACK) begin
          run_frame(surface_e'($urandom_range(0, 2)));
          random_points += grid_cols * grid_rows;
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("height_field_wave_step: match");
    end else begin
      $display("height_field_wave_step: mismatch");
    end
    $finish;
  end

endmodule
